/* rtl/core/array_list_engine_assert.svh */
// ----------------------------------------------------------------------------
// Array list engine assertion macros
// Short forms for the concurrent checks used across the engine.
// ----------------------------------------------------------------------------
`ifndef ARRAY_LIST_ENGINE_ASSERT_SVH
`define ARRAY_LIST_ENGINE_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define ALE_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause
`define ALE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/ale_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_pkg
// Shared types and constants of the array list engine.
// ----------------------------------------------------------------------------
package ale_pkg;

	// Field widths of the item and result channels
	localparam int OPCODE_W    = 4;
	localparam int ELEM_W      = 32;
	localparam int POS_W       = 6;
	localparam int STATUS_W    = 3;
	localparam int INDEX_W     = 6;
	localparam int COUNT_W     = 7;

	// Default list capacity
	localparam int DEPTH_DEFAULT = 32;

	typedef enum logic [OPCODE_W-1:0] {
		OP_CLEAR      = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_BACK   = 4'd2,
		OP_PUSH_FRONT = 4'd3,
		OP_POP_FRONT  = 4'd4,
		OP_FIND       = 4'd5,
		OP_INSERT     = 4'd6,
		OP_ERASE      = 4'd7,
		OP_REMOVE_ONE = 4'd8,
		OP_REMOVE_ALL = 4'd9,
		OP_DUMP       = 4'd10
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_BAD_POS   = 3'd4
	} status_t;

	// One result item as handed from the sequencer to the output register
	typedef struct packed {
		status_t                    status;
		logic [INDEX_W-1:0]         found_index;
		logic signed [ELEM_W-1:0]   dumped_value;
		logic [COUNT_W-1:0]         element_count;
		logic                       last;
	} result_t;

endpackage

/* rtl/core/ale_cmd_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_cmd_if
// Item channel of the array list engine: valid/ready with opcode and operands.
// ----------------------------------------------------------------------------
interface ale_cmd_if;
	logic                                    valid;
	logic                                    ready;
	logic [ale_pkg::OPCODE_W-1:0]            opcode;
	logic signed [ale_pkg::ELEM_W-1:0]       element_value;
	logic [ale_pkg::POS_W-1:0]               position;

	modport source (output valid, output opcode, output element_value, output position,
		input ready);
	modport sink (input valid, input opcode, input element_value, input position,
		output ready);
endinterface

/* rtl/core/ale_rsp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_rsp_if
// Result channel of the array list engine: valid/ready with status and data.
// ----------------------------------------------------------------------------
interface ale_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic [ale_pkg::STATUS_W-1:0]            status;
	logic [ale_pkg::INDEX_W-1:0]             found_index;
	logic signed [ale_pkg::ELEM_W-1:0]       dumped_value;
	logic [ale_pkg::COUNT_W-1:0]             element_count;
	logic                                    last;

	modport source (output valid, output status, output found_index, output dumped_value,
		output element_count, output last, input ready);
	modport sink (input valid, input status, input found_index, input dumped_value,
		input element_count, input last, output ready);
endinterface

/* rtl/core/ale_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ale_ram #(
	parameter int WIDTH = ale_pkg::ELEM_W,
	parameter int DEPTH = ale_pkg::DEPTH_DEFAULT,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write, and register the read word; hold it while no read is issued
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/core/ale_result_reg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_result_reg
// Output register of the result channel; frees the sequencer from the sink.
// ----------------------------------------------------------------------------
module ale_result_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ale_pkg::result_t  res,
	output logic              free,
	ale_rsp_if.source         rsp
);

	logic             valid_q;
	ale_pkg::result_t res_q;

	// Room for a new item when empty or when the held item leaves now
	assign free = !valid_q || rsp.ready;

	// Hold the item until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			res_q   <= res;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign rsp.valid         = valid_q;
	assign rsp.status        = res_q.status;
	assign rsp.found_index   = res_q.found_index;
	assign rsp.dumped_value  = res_q.dumped_value;
	assign rsp.element_count = res_q.element_count;
	assign rsp.last          = res_q.last;

endmodule

/* rtl/core/ale_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ale_seq
// Sequencer of the array list engine: decodes an item, walks the element
// memory to shift, search, compact or dump, and builds the result items.
// ----------------------------------------------------------------------------
`include "array_list_engine_assert.svh"

module ale_seq #(
	parameter int DEPTH = ale_pkg::DEPTH_DEFAULT,
	localparam int IDX_W = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	ale_cmd_if.sink                     cmd,
	output logic                        rd_en,
	output logic [IDX_W-1:0]            rd_addr,
	input  logic [ale_pkg::ELEM_W-1:0]  rd_data,
	output logic                        wr_en,
	output logic [IDX_W-1:0]            wr_addr,
	output logic [ale_pkg::ELEM_W-1:0]  wr_data,
	output logic                        res_load,
	output ale_pkg::result_t            res,
	input  logic                        res_free
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP_UP,
		S_SWEEP_DN,
		S_DUMP,
		S_RESULT
	} state_t;

	state_t                      state_q;
	ale_pkg::opcode_t            op_q;
	ale_pkg::status_t            status_q;
	logic [ale_pkg::ELEM_W-1:0]  value_q;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            pos_q;
	logic [CNT_W-1:0]            rd_ptr_q;
	logic [CNT_W-1:0]            wr_ptr_q;
	logic [IDX_W-1:0]            found_q;
	logic                        hit_q;
	logic                        valid_s1;
	logic [IDX_W-1:0]            idx_s1;

	logic [ale_pkg::COUNT_W-1:0] cnt_ext;
	logic [ale_pkg::COUNT_W-1:0] pos_ext;
	logic [CNT_W-1:0]            pos_cnt;
	logic                        is_full;
	logic                        is_empty;
	logic                        match;
	logic                        first;
	logic                        skip;
	logic                        sweep_done;

	// Compare the operands of a new item against the count
	assign cnt_ext  = ale_pkg::COUNT_W'(count_q);
	assign pos_ext  = {1'b0, cmd.position};
	assign pos_cnt  = CNT_W'(pos_ext);
	assign is_full  = (count_q == FULL_CNT);
	assign is_empty = (count_q == '0);

	assign cmd.ready = (state_q == S_IDLE);

	// Classify the element read in the previous cycle
	always_comb begin
		match = (rd_data == value_q);
		first = match && !hit_q;
		case (op_q)
			ale_pkg::OP_FIND:       skip = 1'b1;
			ale_pkg::OP_REMOVE_ONE: skip = first;
			ale_pkg::OP_REMOVE_ALL: skip = match;
			default:                skip = (CNT_W'(idx_s1) == pos_q);
		endcase
	end

	// Drive the memory ports and the result from the current state
	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = IDX_W'(rd_ptr_q);
		wr_en    = 1'b0;
		wr_addr  = IDX_W'(wr_ptr_q);
		wr_data  = rd_data;
		res_load = 1'b0;
		res.status        = status_q;
		res.found_index   = ale_pkg::INDEX_W'(found_q);
		res.dumped_value  = '0;
		res.element_count = cnt_ext;
		res.last          = 1'b1;
		case (state_q)
			S_SWEEP_UP: begin
				rd_en = (rd_ptr_q < count_q);
				wr_en = valid_s1 && !skip;
			end
			S_SWEEP_DN: begin
				rd_en   = (rd_ptr_q > pos_q);
				rd_addr = IDX_W'(rd_ptr_q - 1'b1);
				if (valid_s1) begin
					wr_en   = 1'b1;
					wr_addr = idx_s1 + 1'b1;
				end else if (!rd_en) begin
					wr_en   = 1'b1;
					wr_addr = IDX_W'(pos_q);
					wr_data = value_q;
				end
			end
			S_DUMP: begin
				res.status       = ale_pkg::ST_OK;
				res.found_index  = '0;
				res.dumped_value = rd_data;
				res.last         = (rd_ptr_q == count_q);
				if (!valid_s1) begin
					rd_en = (rd_ptr_q < count_q);
				end else if (res_free) begin
					res_load = 1'b1;
					rd_en    = (rd_ptr_q < count_q);
				end
			end
			S_RESULT: begin
				res_load = res_free;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
		sweep_done = !rd_en && !valid_s1;
	end

	// Hold state, count and the walk pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= ale_pkg::OP_CLEAR;
			status_q <= ale_pkg::ST_OK;
			value_q  <= '0;
			count_q  <= '0;
			pos_q    <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			found_q  <= '0;
			hit_q    <= 1'b0;
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						op_q     <= ale_pkg::opcode_t'(cmd.opcode);
						value_q  <= cmd.element_value;
						status_q <= ale_pkg::ST_OK;
						found_q  <= '0;
						hit_q    <= 1'b0;
						valid_s1 <= 1'b0;
						rd_ptr_q <= '0;
						wr_ptr_q <= '0;
						pos_q    <= '0;
						state_q  <= S_RESULT;
						case (ale_pkg::opcode_t'(cmd.opcode))
							ale_pkg::OP_CLEAR: begin
								count_q <= '0;
							end
							ale_pkg::OP_PUSH_BACK: begin
								if (is_full) begin
									status_q <= ale_pkg::ST_FULL;
								end else begin
									pos_q    <= count_q;
									rd_ptr_q <= count_q;
									state_q  <= S_SWEEP_DN;
								end
							end
							ale_pkg::OP_PUSH_FRONT: begin
								if (is_full) begin
									status_q <= ale_pkg::ST_FULL;
								end else begin
									rd_ptr_q <= count_q;
									state_q  <= S_SWEEP_DN;
								end
							end
							ale_pkg::OP_INSERT: begin
								if (is_full) begin
									status_q <= ale_pkg::ST_FULL;
								end else if (pos_ext > cnt_ext) begin
									status_q <= ale_pkg::ST_BAD_POS;
								end else begin
									pos_q    <= pos_cnt;
									rd_ptr_q <= count_q;
									state_q  <= S_SWEEP_DN;
								end
							end
							ale_pkg::OP_POP_BACK: begin
								if (is_empty) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else begin
									count_q <= count_q - 1'b1;
								end
							end
							ale_pkg::OP_POP_FRONT: begin
								if (is_empty) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else begin
									state_q <= S_SWEEP_UP;
								end
							end
							ale_pkg::OP_ERASE: begin
								if (is_empty) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else if (pos_ext >= cnt_ext) begin
									status_q <= ale_pkg::ST_BAD_POS;
								end else begin
									pos_q    <= pos_cnt;
									rd_ptr_q <= pos_cnt;
									wr_ptr_q <= pos_cnt;
									state_q  <= S_SWEEP_UP;
								end
							end
							ale_pkg::OP_FIND,
							ale_pkg::OP_REMOVE_ONE,
							ale_pkg::OP_REMOVE_ALL: begin
								if (is_empty) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else begin
									state_q <= S_SWEEP_UP;
								end
							end
							ale_pkg::OP_DUMP: begin
								if (is_empty) begin
									status_q <= ale_pkg::ST_EMPTY;
								end else begin
									state_q <= S_DUMP;
								end
							end
							default: begin
								state_q <= S_RESULT;
							end
						endcase
					end
				end
				// Read ahead and write back behind, dropping skipped elements
				S_SWEEP_UP: begin
					valid_s1 <= rd_en;
					idx_s1   <= rd_addr;
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
					if (wr_en) begin
						wr_ptr_q <= wr_ptr_q + 1'b1;
					end
					if (valid_s1 && first && (op_q == ale_pkg::OP_FIND ||
						op_q == ale_pkg::OP_REMOVE_ONE)) begin
						hit_q <= 1'b1;
						if (op_q == ale_pkg::OP_FIND) begin
							found_q <= idx_s1;
						end
					end
					if (sweep_done) begin
						if (op_q != ale_pkg::OP_FIND) begin
							count_q <= wr_ptr_q;
						end
						if ((op_q == ale_pkg::OP_FIND || op_q == ale_pkg::OP_REMOVE_ONE)
							&& !hit_q) begin
							status_q <= ale_pkg::ST_NOT_FOUND;
						end
						state_q <= S_RESULT;
					end
				end
				// Move elements up one place from the top, then place the new one
				S_SWEEP_DN: begin
					valid_s1 <= rd_en;
					idx_s1   <= rd_addr;
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
					if (sweep_done) begin
						count_q <= count_q + 1'b1;
						state_q <= S_RESULT;
					end
				end
				// Emit one element per free output slot
				S_DUMP: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
						valid_s1 <= 1'b1;
					end else if (res_load) begin
						valid_s1 <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				S_RESULT: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ALE_ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= FULL_CNT, "count beyond depth")
	`ALE_ASSERT_IMPL(a_no_rw_clash, clk, arst_n, rd_en && wr_en, rd_addr != wr_addr, "read and write hit one entry")
	`ALE_ASSERT_NEXT(a_accept_leaves_idle, clk, arst_n, cmd.valid && cmd.ready, state_q != S_IDLE, "item accepted without work")
	`ALE_ASSERT_NEXT(a_dump_stall_holds, clk, arst_n, state_q == S_DUMP && valid_s1 && !res_free, $stable(rd_data), "dump word lost during stall")

endmodule

/* rtl/core/array_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_list_engine
// Packed list of signed 32-bit elements with a count, kept in one RAM.
// ----------------------------------------------------------------------------
// The engine takes one item at a time and gives its results on the result
// channel through an output register, so a new item is taken while the last
// result still waits. Clear, pop back, the unused opcodes and every rejected
// item go from acceptance straight to loading the result. Push front and
// insert walk the elements above the position, one RAM read per cycle, and
// then place the new element; push back has no element above its position
// and only places it. Pop front, erase, find, remove one and remove all walk
// from the start (or the erase position) to the count. A dump gives one
// element per cycle while the sink takes them. The next item is taken in the
// cycle after the last result is loaded, and a held result that the sink has
// not taken stalls the load for as long as it waits. The single read port of
// the element RAM paces these walks. The element RAM needs no clearing after
// reset; only entries below the count are ever read.
// ----------------------------------------------------------------------------
module array_list_engine #(
	parameter int DEPTH = ale_pkg::DEPTH_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	ale_cmd_if.sink     cmd,
	ale_rsp_if.source   rsp
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                        rd_en;
	logic [IDX_W-1:0]            rd_addr;
	logic [ale_pkg::ELEM_W-1:0]  rd_data;
	logic                        wr_en;
	logic [IDX_W-1:0]            wr_addr;
	logic [ale_pkg::ELEM_W-1:0]  wr_data;
	logic                        res_load;
	logic                        res_free;
	ale_pkg::result_t            res;

	// Element store
	ale_ram #(
		.WIDTH (ale_pkg::ELEM_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Decode and walk
	ale_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.res_load (res_load),
		.res      (res),
		.res_free (res_free)
	);

	// Result output register
	ale_result_reg u_result (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (res_load),
		.res    (res),
		.free   (res_free),
		.rsp    (rsp)
	);

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the array list engine. A shadow copy of the list
// predicts every result of each accepted item, and results are checked field
// by field in order. A directed pass covers empty-list cases, the extreme
// values, bad positions and each opcode. Random phases then grow, mix and
// shrink the list until it fills and empties again. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
	import ale_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEFAULT;
	localparam int CLK_HALF = 4;
	localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX = 10;
	localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
	// Opcodes the engine leaves undecoded
	localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 4'd11;
	localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 4'd15;

	typedef enum int {PH_GROW, PH_MIXED, PH_SHRINK} phase_kind_e;

	// Shadow list: predicts the results of each item and holds them in order
	class list_shadow;
		logic signed [ELEM_W-1:0] elems [LIST_DEPTH];
		int unsigned n_elems;
		result_t pending[$];
		int mismatches;

		function new();
			n_elems = 0;
			mismatches = 0;
		endfunction

		function void push_result(status_t st, int idx, logic signed [ELEM_W-1:0] val,
			bit fin);
			result_t r;
			r.status = st;
			r.found_index = INDEX_W'(idx);
			r.dumped_value = val;
			r.element_count = COUNT_W'(n_elems);
			r.last = fin;
			pending.push_back(r);
		endfunction

		function int find_first(logic signed [ELEM_W-1:0] v);
			for (int i = 0; i < n_elems; i++)
				if (elems[i] == v)
					return i;
			return -1;
		endfunction

		function void insert_at(int unsigned p, logic signed [ELEM_W-1:0] v);
			for (int unsigned i = n_elems; i > p; i--)
				elems[i] = elems[i - 1];
			elems[p] = v;
			n_elems++;
		endfunction

		function void erase_at(int unsigned p);
			for (int unsigned i = p; i + 1 < n_elems; i++)
				elems[i] = elems[i + 1];
			n_elems--;
		endfunction

		// Advance the shadow list by one item and queue what it must produce
		function void apply_command(logic [OPCODE_W-1:0] op, logic signed [ELEM_W-1:0] v,
			logic [POS_W-1:0] pos);
			status_t st;
			int idx;
			int at;
			int kept;
			st = ST_OK;
			idx = 0;
			case (op)
				OP_CLEAR: n_elems = 0;
				OP_PUSH_BACK: begin
					if (n_elems >= LIST_DEPTH) st = ST_FULL;
					else insert_at(n_elems, v);
				end
				OP_POP_BACK: begin
					if (n_elems == 0) st = ST_EMPTY;
					else n_elems--;
				end
				OP_PUSH_FRONT: begin
					if (n_elems >= LIST_DEPTH) st = ST_FULL;
					else insert_at(0, v);
				end
				OP_POP_FRONT: begin
					if (n_elems == 0) st = ST_EMPTY;
					else erase_at(0);
				end
				OP_FIND: begin
					if (n_elems == 0) st = ST_EMPTY;
					else begin
						at = find_first(v);
						if (at < 0) st = ST_NOT_FOUND;
						else idx = at;
					end
				end
				OP_INSERT: begin
					if (n_elems >= LIST_DEPTH) st = ST_FULL;
					else if (pos > n_elems) st = ST_BAD_POS;
					else insert_at(pos, v);
				end
				OP_ERASE: begin
					if (n_elems == 0) st = ST_EMPTY;
					else if (pos >= n_elems) st = ST_BAD_POS;
					else erase_at(pos);
				end
				OP_REMOVE_ONE: begin
					if (n_elems == 0) st = ST_EMPTY;
					else begin
						at = find_first(v);
						if (at < 0) st = ST_NOT_FOUND;
						else erase_at(at);
					end
				end
				OP_REMOVE_ALL: begin
					if (n_elems == 0) st = ST_EMPTY;
					else begin
						// compact the survivors towards the front
						kept = 0;
						for (int i = 0; i < n_elems; i++)
							if (elems[i] != v) begin
								elems[kept] = elems[i];
								kept++;
							end
						n_elems = kept;
					end
				end
				OP_DUMP: begin
					if (n_elems == 0) st = ST_EMPTY;
					else begin
						for (int i = 0; i < n_elems; i++)
							push_result(ST_OK, 0, elems[i], i + 1 == n_elems);
						return;
					end
				end
				default: ;
			endcase
			push_result(st, idx, '0, 1'b1);
		endfunction

		// Compare one delivered result with the oldest prediction
		function void check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected result: st=%0d idx=%0d val=%0d cnt=%0d last=%0b",
						got.status, got.found_index, got.dumped_value,
						got.element_count, got.last);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status || got.found_index !== want.found_index ||
				got.dumped_value !== want.dumped_value ||
				got.element_count !== want.element_count || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result mismatch: expected st=%0d idx=%0d val=%0d cnt=%0d last=%0b,%s",
						want.status, want.found_index, want.dumped_value,
						want.element_count, want.last, "");
				if (mismatches <= REPORT_MAX)
					$display("                 actual   st=%0d idx=%0d val=%0d cnt=%0d last=%0b",
						got.status, got.found_index, got.dumped_value,
						got.element_count, got.last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	bit no_idle;
	int unsigned cycles;
	logic signed [ELEM_W-1:0] value_pool [8];
	list_shadow sb;

	ale_cmd_if cmd_ch();
	ale_rsp_if rsp_ch();

	array_list_engine #(
		.DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Abort a run that hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one item after a random gap and hold it until taken
	task automatic send_item(logic [OPCODE_W-1:0] op, logic signed [ELEM_W-1:0] v,
		logic [POS_W-1:0] pos);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 9);
		@(negedge clk);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd_ch.opcode <= op;
		cmd_ch.element_value <= v;
		cmd_ch.position <= pos;
		cmd_ch.valid <= 1'b1;
		do @(posedge clk); while (!cmd_ch.ready);
		sb.apply_command(op, v, pos);
	endtask

	function automatic logic signed [ELEM_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 70)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	function automatic logic [POS_W-1:0] pick_position(int unsigned n);
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return POS_W'($urandom_range(0, (1 << POS_W) - 1));
		if (r < 60) return POS_W'($urandom_range(0, n));
		return POS_W'($urandom_range(0, (n > 0) ? n - 1 : 0));
	endfunction

	// Drive one phase of random items, biased towards growing or shrinking outside the mixed phase
	task automatic run_phase(phase_kind_e kind, int n_items);
		logic [OPCODE_W-1:0] op;
		int r;
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(0, 99);
			op = OPCODE_W'($urandom_range(0, (1 << OPCODE_W) - 1));
			case (kind)
				PH_GROW: begin
					if (r < 45) op = OP_PUSH_BACK;
					else if (r < 65) op = OP_PUSH_FRONT;
					else if (r < 85) op = OP_INSERT;
					else if (r < 90) op = OP_DUMP;
					else if (r < 95) op = OP_FIND;
				end
				PH_SHRINK: begin
					if (r < 20) op = OP_POP_BACK;
					else if (r < 35) op = OP_POP_FRONT;
					else if (r < 55) op = OP_ERASE;
					else if (r < 70) op = OP_REMOVE_ONE;
					else if (r < 80) op = OP_REMOVE_ALL;
					else if (r < 88) op = OP_FIND;
					else if (r < 93) op = OP_DUMP;
				end
				default: begin
					// keep clears rare so the list has something to work on
					if (op == OP_CLEAR && r >= 20) op = OP_FIND;
				end
			endcase
			send_item(op, pick_value(), pick_position(sb.n_elems));
		end
	endtask

	// Take results after a random stall and check each one
	initial begin
		result_t got;
		int stall;
		@(posedge arst_n);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 9);
			@(negedge clk);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.status = status_t'(rsp_ch.status);
			got.found_index = rsp_ch.found_index;
			got.dumped_value = rsp_ch.dumped_value;
			got.element_count = rsp_ch.element_count;
			got.last = rsp_ch.last;
			sb.check_result(got);
		end
	end

	// Reset, directed items, random phases, then drain
	initial begin
		sb = new();
		no_idle = 1'b0;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.opcode = OP_CLEAR;
		cmd_ch.element_value = '0;
		cmd_ch.position = '0;
		rsp_ch.ready = 1'b0;
		value_pool[0] = ELEM_MAX;
		value_pool[1] = ELEM_MIN;
		value_pool[2] = '0;
		value_pool[3] = -1;
		value_pool[4] = 1;
		for (int i = 5; i < 8; i++)
			value_pool[i] = $urandom;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty list: every reader reports empty
		send_item(OP_POP_BACK, 0, 0);
		send_item(OP_POP_FRONT, 0, 0);
		send_item(OP_FIND, -1, 0);
		send_item(OP_ERASE, 0, 0);
		send_item(OP_REMOVE_ONE, 5, 0);
		send_item(OP_REMOVE_ALL, 5, 0);
		send_item(OP_DUMP, 0, 0);
		// build a short list with the extreme values
		send_item(OP_PUSH_BACK, ELEM_MAX, 0);
		send_item(OP_PUSH_BACK, ELEM_MIN, 0);
		send_item(OP_PUSH_FRONT, -1, 0);
		send_item(OP_INSERT, 0, 3);
		// insert beyond the count, erase at the count
		send_item(OP_INSERT, 7, 5);
		send_item(OP_INSERT, 7, '1);
		send_item(OP_ERASE, 0, 4);
		// searches that hit and miss
		send_item(OP_FIND, ELEM_MIN, 0);
		send_item(OP_FIND, 12345, 0);
		send_item(OP_PUSH_BACK, -1, 0);
		send_item(OP_REMOVE_ONE, 77, 0);
		send_item(OP_REMOVE_ONE, ELEM_MAX, 0);
		send_item(OP_REMOVE_ALL, -1, 0);
		send_item(OP_REMOVE_ALL, 999, 0);
		send_item(OP_DUMP, 0, 0);
		send_item(OP_ERASE, 0, 0);
		send_item(OP_SPARE_LO, ELEM_MAX, '1);
		send_item(OP_SPARE_HI, 0, 0);
		send_item(OP_CLEAR, 0, 0);

		// random phases: the grow phases run long enough to fill the list
		for (int ph = 0; ph < 6; ph++) begin
			no_idle = (ph == 1 || ph == 4);
			case (ph % 3)
				0: run_phase(PH_GROW, 45);
				1: run_phase(PH_MIXED, 10);
				default: run_phase(PH_SHRINK, 18);
			endcase
		end
		no_idle = 1'b0;
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// wait for every predicted result, then watch for strays
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
